[hw/rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, constants and helper functions for the MUS to MIDI event
// converter: parse phases, MIDI status codes, controller map, result word.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

	// widths
	localparam int DELTA_BITS_DEF = 32;
	localparam int DELTA_OUT_W    = 32;
	localparam int CHAN_W         = 4;
	localparam int NUM_CHANS      = 16;

	// parse phase
	typedef enum logic [2:0] {
		PH_DESC  = 3'd0,
		PH_P1    = 3'd1,
		PH_P2    = 3'd2,
		PH_DELTA = 3'd3
	} phase_t;

	// mus event kinds
	localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
	localparam logic [2:0] KIND_PITCH    = 3'd2;
	localparam logic [2:0] KIND_SYSTEM   = 3'd3;
	localparam logic [2:0] KIND_CTRL     = 3'd4;
	localparam logic [2:0] KIND_BAD5     = 3'd5;
	localparam logic [2:0] KIND_END      = 3'd6;
	localparam logic [2:0] KIND_BAD7     = 3'd7;

	// midi status high nibbles
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_CTRL     = 8'hb0;
	localparam logic [7:0] ST_PROGRAM  = 8'hc0;
	localparam logic [7:0] ST_PITCH    = 8'he0;
	localparam logic [7:0] DATA_MASK   = 8'h7f;

	localparam logic [7:0] CTRL_MAX    = 8'd14;
	localparam logic [7:0] VOL_RESET   = 8'd64;

	localparam logic [3:0] CH_PERC_MUS  = 4'd15;
	localparam logic [3:0] CH_PERC_MIDI = 4'd9;

	// volume table write port
	typedef struct packed {
		logic              en;
		logic [CHAN_W-1:0] ch;
		logic [7:0]        data;
	} vol_wr_t;

	// one result word
	typedef struct packed {
		logic [DELTA_OUT_W-1:0] delta_ticks;
		logic [7:0]             status;
		logic [7:0]             data1;
		logic [7:0]             data2;
		logic                   score_end;
		logic                   bad_event;
	} res_t;

	// mus controller number to midi controller number, n in 0..14
	function automatic logic [7:0] ctrl_map(input logic [3:0] n);
		logic [7:0] r;
		case (n)
			4'd0:    r = 8'd0;
			4'd1:    r = 8'd0;
			4'd2:    r = 8'd1;
			4'd3:    r = 8'd7;
			4'd4:    r = 8'd10;
			4'd5:    r = 8'd11;
			4'd6:    r = 8'd91;
			4'd7:    r = 8'd93;
			4'd8:    r = 8'd64;
			4'd9:    r = 8'd67;
			4'd10:   r = 8'd120;
			4'd11:   r = 8'd123;
			4'd12:   r = 8'd126;
			4'd13:   r = 8'd127;
			4'd14:   r = 8'd121;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// swap percussion channels between mus and midi numbering
	function automatic logic [3:0] midi_chan(input logic [3:0] c);
		logic [3:0] r;
		if (c == CH_PERC_MUS) begin
			r = CH_PERC_MIDI;
		end else if (c == CH_PERC_MIDI) begin
			r = CH_PERC_MUS;
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/mus_to_midi_event_converter.sv]
// ----------------------------------------------------------------------------
// mus_to_midi_event_converter
// Converts a MUS score byte stream into MIDI short messages with delta time.
//
//   channel  dir  tdata                        tuser
//   s_*      in   score_byte[7:0]              start_req
//   m_*      out  delta, status, data1, data2  score_end, bad_event
//
// One byte per cycle sustained; an input word reaches the result word through
// an input register, the parse logic, then the result register.
// A byte that gives no result still passes through the input register.
// The input side stalls only when a result waits in the output register
// and m_tready is low. Reset clears the parse state and sets all channel
// volumes to 64; start_req keeps the volumes.
// ----------------------------------------------------------------------------
`default_nettype none

module mus_to_midi_event_converter #(
	parameter int DELTA_BITS = mme_pkg::DELTA_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] score_byte
	input  wire logic [0:0]  s_tuser,   // [0] start_req
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // [31:0] delta_ticks, [39:32] status,
	                                    // [47:40] data1, [55:48] data2
	output logic [1:0]       m_tuser    // [0] score_end, [1] bad_event
);

	logic                               valid_s1;
	logic [7:0]                         byte_s1;
	logic                               start_s1;
	logic                               advance;
	logic                               res_valid;
	mme_pkg::res_t                      res;
	mme_pkg::res_t                      res_s2;
	logic                               valid_s2;
	mme_pkg::vol_wr_t                   vol_wr;
	logic [mme_pkg::CHAN_W-1:0]         vol_rd_ch;
	logic [7:0]                         vol_rd_data;

	// stage 1 moves on when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	mme_parser #(
		.DELTA_BITS (DELTA_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.score_byte  (byte_s1),
		.start_req   (start_s1),
		.res_valid   (res_valid),
		.res         (res),
		.vol_wr      (vol_wr),
		.vol_rd_ch   (vol_rd_ch),
		.vol_rd_data (vol_rd_data)
	);

	mme_vol_table u_vol (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (vol_wr),
		.rd_ch   (vol_rd_ch),
		.rd_data (vol_rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (advance && res_valid) begin
				valid_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.data2, res_s2.data1, res_s2.status, res_s2.delta_ticks};
	assign m_tuser  = {res_s2.bad_event, res_s2.score_end};

`ifndef SYNTH
	// a held input word is not overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input stage overwritten while stalled");

	// end and error never flagged together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("score_end and bad_event both set");

	// end result carries no message
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[55:32] == 24'd0))
		else $error("score end result carries message bytes");

	// error result is either blank or a controller message without data
	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |->
		((m_tdata[39:32] == 8'd0 || m_tdata[39:36] == 4'hb) && m_tdata[55:40] == 16'd0))
		else $error("malformed bad event result");
`endif

endmodule

`default_nettype wire

[hw/rtl/mme_vol_table.sv]
// ----------------------------------------------------------------------------
// mme_vol_table
// Per-channel note-on volume, 16 entries of 8 bits, reset to 64 each.
// One combinational read port, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_vol_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mme_pkg::vol_wr_t            wr,
	input  wire logic [mme_pkg::CHAN_W-1:0]  rd_ch,
	output logic [7:0]                       rd_data
);

	logic [7:0] vol_q [mme_pkg::NUM_CHANS];

	// storage, every entry back to the default volume on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mme_pkg::NUM_CHANS; i++) begin
				vol_q[i] <= mme_pkg::VOL_RESET;
			end
		end else if (wr.en) begin
			vol_q[wr.ch] <= wr.data;
		end
	end

	assign rd_data = vol_q[rd_ch];

endmodule

`default_nettype wire

[hw/rtl/mme_parser.sv]
// ----------------------------------------------------------------------------
// mme_parser
// Score byte parser: holds the parse state, decodes one byte per step and
// builds at most one midi result word for it. Accumulates delta varints.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_parser #(
	parameter int DELTA_BITS = mme_pkg::DELTA_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [7:0]                  score_byte,
	input  wire logic                        start_req,
	output logic                             res_valid,
	output mme_pkg::res_t                    res,
	output mme_pkg::vol_wr_t                 vol_wr,
	output logic [mme_pkg::CHAN_W-1:0]       vol_rd_ch,
	input  wire logic [7:0]                  vol_rd_data
);

	mme_pkg::phase_t                phase_q, phase_cur, phase_d;
	logic [mme_pkg::CHAN_W-1:0]     chan_q, chan_d;
	logic [2:0]                     kind_q, kind_d;
	logic                           last_q, last_d;
	logic [7:0]                     param_q, param_d;
	logic [DELTA_BITS-1:0]          delta_q, delta_cur, delta_d, delta_acc;
	logic                           done_q, done_cur, done_d;
	logic                           emit;
	logic [3:0]                     ch;
	logic [2:0]                     b_kind;

	// start request clears the parse position, delta and end mark
	assign phase_cur = start_req ? mme_pkg::PH_DESC : phase_q;
	assign delta_cur = start_req ? '0 : delta_q;
	assign done_cur  = start_req ? 1'b0 : done_q;

	assign ch        = mme_pkg::midi_chan(chan_q);
	assign b_kind    = score_byte[6:4];
	assign vol_rd_ch = chan_q;

	// varint accumulate with saturation
	always_comb begin
		if (delta_cur[DELTA_BITS-1 -: 7] != 7'd0) begin
			delta_acc = '1;
		end else begin
			delta_acc = {delta_cur[DELTA_BITS-8:0], score_byte[6:0]};
		end
	end

	// output decode: result word and volume write
	always_comb begin
		emit    = 1'b0;
		res     = '0;
		vol_wr  = '0;
		res.delta_ticks = mme_pkg::DELTA_OUT_W'(delta_cur);
		if (!done_cur) begin
			case (phase_cur)
				mme_pkg::PH_DESC: begin
					if (b_kind == mme_pkg::KIND_END) begin
						emit          = 1'b1;
						res.score_end = 1'b1;
					end else if (b_kind == mme_pkg::KIND_BAD5 ||
							b_kind == mme_pkg::KIND_BAD7) begin
						emit          = 1'b1;
						res.bad_event = 1'b1;
					end
				end
				mme_pkg::PH_P1: begin
					case (kind_q)
						mme_pkg::KIND_NOTE_OFF: begin
							emit       = 1'b1;
							res.status = mme_pkg::ST_NOTE_OFF | {4'd0, ch};
							res.data1  = score_byte;
						end
						mme_pkg::KIND_NOTE_ON: begin
							if (!score_byte[7]) begin
								emit       = 1'b1;
								res.status = mme_pkg::ST_NOTE_ON | {4'd0, ch};
								res.data1  = score_byte & mme_pkg::DATA_MASK;
								res.data2  = vol_rd_data;
							end
						end
						mme_pkg::KIND_PITCH: begin
							// b << 6 split into 7-bit halves
							emit       = 1'b1;
							res.status = mme_pkg::ST_PITCH | {4'd0, ch};
							res.data1  = {1'b0, score_byte[0], 6'd0};
							res.data2  = {1'b0, score_byte[7:1]};
						end
						mme_pkg::KIND_SYSTEM: begin
							emit       = 1'b1;
							res.status = mme_pkg::ST_CTRL | {4'd0, ch};
							if (score_byte > mme_pkg::CTRL_MAX) begin
								res.bad_event = 1'b1;
							end else begin
								res.data1 = mme_pkg::ctrl_map(score_byte[3:0]);
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
				mme_pkg::PH_P2: begin
					emit = 1'b1;
					if (kind_q == mme_pkg::KIND_NOTE_ON) begin
						vol_wr.en   = 1'b1;
						vol_wr.ch   = chan_q;
						vol_wr.data = score_byte;
						res.status  = mme_pkg::ST_NOTE_ON | {4'd0, ch};
						res.data1   = param_q & mme_pkg::DATA_MASK;
						res.data2   = score_byte;
					end else if (param_q == 8'd0) begin
						res.status = mme_pkg::ST_PROGRAM | {4'd0, ch};
						res.data1  = score_byte;
					end else if (param_q > mme_pkg::CTRL_MAX) begin
						res.status    = mme_pkg::ST_CTRL | {4'd0, ch};
						res.bad_event = 1'b1;
					end else begin
						res.status = mme_pkg::ST_CTRL | {4'd0, ch};
						res.data1  = mme_pkg::ctrl_map(param_q[3:0]);
						res.data2  = score_byte;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
		res_valid = emit;
		if (!step) begin
			vol_wr.en = 1'b0;
		end
	end

	// next parse state
	always_comb begin
		phase_d = phase_cur;
		chan_d  = chan_q;
		kind_d  = kind_q;
		last_d  = last_q;
		param_d = param_q;
		delta_d = delta_cur;
		done_d  = done_cur;
		if (!done_cur) begin
			case (phase_cur)
				mme_pkg::PH_DESC: begin
					chan_d = score_byte[3:0];
					kind_d = b_kind;
					last_d = score_byte[7];
					if (b_kind == mme_pkg::KIND_END) begin
						last_d = 1'b0;
						done_d = 1'b1;
					end else if (b_kind != mme_pkg::KIND_BAD5 &&
							b_kind != mme_pkg::KIND_BAD7) begin
						phase_d = mme_pkg::PH_P1;
					end
				end
				mme_pkg::PH_P1: begin
					case (kind_q)
						mme_pkg::KIND_NOTE_ON: begin
							if (score_byte[7]) begin
								param_d = score_byte;
								phase_d = mme_pkg::PH_P2;
							end
						end
						mme_pkg::KIND_NOTE_OFF, mme_pkg::KIND_PITCH,
						mme_pkg::KIND_SYSTEM: begin
							param_d = param_q;
						end
						default: begin
							param_d = score_byte;
							phase_d = mme_pkg::PH_P2;
						end
					endcase
				end
				mme_pkg::PH_P2: begin
					phase_d = mme_pkg::PH_DESC;
				end
				mme_pkg::PH_DELTA: begin
					delta_d = delta_acc;
					if (!score_byte[7]) begin
						phase_d = mme_pkg::PH_DESC;
					end
				end
				default: begin
					phase_d = mme_pkg::PH_DESC;
				end
			endcase
			// a message consumes the pending delta
			if (emit) begin
				delta_d = '0;
				phase_d = last_d ? mme_pkg::PH_DELTA : mme_pkg::PH_DESC;
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mme_pkg::PH_DESC;
			chan_q  <= '0;
			kind_q  <= '0;
			last_q  <= 1'b0;
			param_q <= '0;
			delta_q <= '0;
			done_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			chan_q  <= chan_d;
			kind_q  <= kind_d;
			last_q  <= last_d;
			param_q <= param_d;
			delta_q <= delta_d;
			done_q  <= done_d;
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MUS to MIDI event converter. Score bytes go in
// as stream words with random gaps, and the output side stalls at random.
// A local model of the parser predicts each MIDI result word, and the
// checker compares every result word field by field with the oldest
// prediction. Directed event sequences come first, then random scores.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int          DELTA_W     = mme_pkg::DELTA_BITS_DEF;
	localparam logic [38:0] DELTA_SAT   = (39'd1 << DELTA_W) - 39'd1;
	localparam int          RAND_BYTES  = 1150;
	localparam int          STALL_LIMIT = 2000;
	localparam int          DRAIN_WAIT  = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] score_byte
	logic [0:0]  s_tuser;   // [0] start_req
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // [31:0] delta_ticks, [39:32] status, [47:40] data1, [55:48] data2
	logic [1:0]  m_tuser;   // [0] score_end, [1] bad_event

	// parser model state
	mme_pkg::phase_t cur_phase;
	logic [3:0]      cur_chan;
	logic [2:0]      cur_kind;
	logic            cur_last;
	logic [7:0]      first_p;
	logic [7:0]      chan_vol [mme_pkg::NUM_CHANS];
	logic [31:0]     acc_delta;
	logic            score_over;

	mme_pkg::res_t midi_msg_q[$];
	int            err_cnt;
	int            bytes_sent;
	logic          idle_off;
	int            ready_hold;

	mus_to_midi_event_converter #(
		.DELTA_BITS(DELTA_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mus controller number to midi controller number
	function automatic logic [7:0] midi_ctl_num(input logic [3:0] n);
		case (n)
			4'd2:    return 8'd1;
			4'd3:    return 8'd7;
			4'd4:    return 8'd10;
			4'd5:    return 8'd11;
			4'd6:    return 8'd91;
			4'd7:    return 8'd93;
			4'd8:    return 8'd64;
			4'd9:    return 8'd67;
			4'd10:   return 8'd120;
			4'd11:   return 8'd123;
			4'd12:   return 8'd126;
			4'd13:   return 8'd127;
			4'd14:   return 8'd121;
			default: return 8'd0;
		endcase
	endfunction

	// record one expected message, then clear the delta and move on
	function automatic void queue_msg(input logic [7:0] st, input logic [7:0] d1,
		input logic [7:0] d2, input logic fin, input logic bad);
		mme_pkg::res_t m;
		m.delta_ticks = acc_delta;
		m.status      = st;
		m.data1       = d1;
		m.data2       = d2;
		m.score_end   = fin;
		m.bad_event   = bad;
		midi_msg_q.push_back(m);
		acc_delta = '0;
		cur_phase = cur_last ? mme_pkg::PH_DELTA : mme_pkg::PH_DESC;
	endfunction

	// advance the parser model by one accepted score byte
	function automatic void convert_byte(input logic [7:0] b, input logic st);
		logic [3:0]  mch;
		logic [13:0] bend;
		logic [38:0] acc;
		if (st) begin
			cur_phase  = mme_pkg::PH_DESC;
			acc_delta  = '0;
			score_over = 1'b0;
		end
		if (score_over) return;
		// percussion channel swap
		if (cur_chan == mme_pkg::CH_PERC_MUS) begin
			mch = mme_pkg::CH_PERC_MIDI;
		end else if (cur_chan == mme_pkg::CH_PERC_MIDI) begin
			mch = mme_pkg::CH_PERC_MUS;
		end else begin
			mch = cur_chan;
		end
		case (cur_phase)
			mme_pkg::PH_DESC: begin
				cur_chan = b[3:0];
				cur_kind = b[6:4];
				cur_last = b[7];
				if (cur_kind == mme_pkg::KIND_END) begin
					cur_last = 1'b0;
					queue_msg(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
					score_over = 1'b1;
				end else if (cur_kind == mme_pkg::KIND_BAD5 ||
						cur_kind == mme_pkg::KIND_BAD7) begin
					queue_msg(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
				end else begin
					cur_phase = mme_pkg::PH_P1;
				end
			end
			mme_pkg::PH_P1: begin
				case (cur_kind)
					mme_pkg::KIND_NOTE_OFF:
						queue_msg(mme_pkg::ST_NOTE_OFF | {4'h0, mch}, b, 8'h00,
							1'b0, 1'b0);
					mme_pkg::KIND_NOTE_ON: begin
						if (b[7]) begin
							first_p   = b;
							cur_phase = mme_pkg::PH_P2;
						end else begin
							queue_msg(mme_pkg::ST_NOTE_ON | {4'h0, mch},
								b & mme_pkg::DATA_MASK, chan_vol[cur_chan], 1'b0, 1'b0);
						end
					end
					mme_pkg::KIND_PITCH: begin
						bend = {b, 6'b0};
						queue_msg(mme_pkg::ST_PITCH | {4'h0, mch}, {1'b0, bend[6:0]},
							{1'b0, bend[13:7]}, 1'b0, 1'b0);
					end
					mme_pkg::KIND_SYSTEM: begin
						if (b > mme_pkg::CTRL_MAX) begin
							queue_msg(mme_pkg::ST_CTRL | {4'h0, mch}, 8'h00, 8'h00,
								1'b0, 1'b1);
						end else begin
							queue_msg(mme_pkg::ST_CTRL | {4'h0, mch},
								midi_ctl_num(b[3:0]), 8'h00, 1'b0, 1'b0);
						end
					end
					default: begin
						first_p   = b;
						cur_phase = mme_pkg::PH_P2;
					end
				endcase
			end
			mme_pkg::PH_P2: begin
				if (cur_kind == mme_pkg::KIND_NOTE_ON) begin
					chan_vol[cur_chan] = b;
					queue_msg(mme_pkg::ST_NOTE_ON | {4'h0, mch},
						first_p & mme_pkg::DATA_MASK, b, 1'b0, 1'b0);
				end else if (first_p == 8'h00) begin
					// instrument controller becomes a program change
					queue_msg(mme_pkg::ST_PROGRAM | {4'h0, mch}, b, 8'h00, 1'b0, 1'b0);
				end else if (first_p > mme_pkg::CTRL_MAX) begin
					queue_msg(mme_pkg::ST_CTRL | {4'h0, mch}, 8'h00, 8'h00, 1'b0, 1'b1);
				end else begin
					queue_msg(mme_pkg::ST_CTRL | {4'h0, mch}, midi_ctl_num(first_p[3:0]),
						b, 1'b0, 1'b0);
				end
			end
			default: begin
				// delta varint, saturating
				acc = {acc_delta, b[6:0]};
				if (acc > DELTA_SAT) acc = DELTA_SAT;
				acc_delta = acc[31:0];
				if (!b[7]) cur_phase = mme_pkg::PH_DESC;
			end
		endcase
	endfunction

	// gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// controller number: often program, mostly in table, sometimes any byte
	function automatic logic [7:0] pick_ctl_num();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return 8'd0;
		if (r < 85) return 8'($urandom_range(1, 14));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] mus_desc(input logic last, input logic [2:0] kind,
		input logic [3:0] chan);
		return {last, kind, chan};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
	endtask

	// send one input word, starting and ending at a falling edge
	task automatic send_word(input logic [7:0] b, input logic st);
		int gap;
		s_tdata  = b;
		s_tuser  = st;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		convert_byte(b, st);
		bytes_sent++;
		@(negedge clk);
		gap = idle_off ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold off the sender until every expected word has come out
	task automatic wait_for_drain();
		s_tvalid = 1'b0;
		while (midi_msg_q.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic send_rand_delta();
		int nb;
		int r;
		r = $urandom_range(0, 99);
		nb = (r < 65) ? 1 : (r < 92) ? $urandom_range(2, 3) : $urandom_range(4, 6);
		for (int i = 0; i < nb; i++)
			send_word({(i != nb - 1), 7'($urandom)}, 1'b0);
	endtask

	task automatic send_rand_event(input logic st, input logic last);
		int         r;
		logic [2:0] kind;
		logic [7:0] p;
		r = $urandom_range(0, 99);
		if (r < 16)      kind = mme_pkg::KIND_NOTE_OFF;
		else if (r < 40) kind = mme_pkg::KIND_NOTE_ON;
		else if (r < 52) kind = mme_pkg::KIND_PITCH;
		else if (r < 64) kind = mme_pkg::KIND_SYSTEM;
		else if (r < 90) kind = mme_pkg::KIND_CTRL;
		else if (r < 95) kind = mme_pkg::KIND_BAD5;
		else             kind = mme_pkg::KIND_BAD7;
		send_word(mus_desc(last, kind, 4'($urandom_range(0, 15))), st);
		case (kind)
			mme_pkg::KIND_NOTE_OFF, mme_pkg::KIND_PITCH: send_word(8'($urandom), 1'b0);
			mme_pkg::KIND_NOTE_ON: begin
				p = 8'($urandom);
				send_word(p, 1'b0);
				if (p[7]) send_word(8'($urandom), 1'b0);
			end
			mme_pkg::KIND_SYSTEM: send_word(pick_ctl_num(), 1'b0);
			mme_pkg::KIND_CTRL: begin
				send_word(pick_ctl_num(), 1'b0);
				send_word(8'($urandom), 1'b0);
			end
			default: ;
		endcase
	endtask

	// well-formed score with random content, mostly ended, sometimes cut short
	task automatic send_rand_score(input int n_ev);
		int   r;
		logic last;
		for (int i = 0; i < n_ev; i++) begin
			last = ($urandom_range(0, 99) < 35);
			send_rand_event(i == 0, last);
			if (last) send_rand_delta();
		end
		r = $urandom_range(0, 99);
		if (r < 75) begin
			send_word(mus_desc(1'($urandom), mme_pkg::KIND_END, 4'($urandom)), 1'b0);
			repeat ($urandom_range(0, 3)) send_word(8'($urandom), 1'b0);
		end else if (r >= 88) begin
			send_word(mus_desc(1'b0, mme_pkg::KIND_CTRL, 4'($urandom)), 1'b0);
			if ($urandom_range(0, 1)) send_word(8'($urandom), 1'b0);
		end
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_word(8'($urandom), 1'($urandom_range(0, 9) == 0));
	endtask

	// every event kind but score end, controller limits, channel swap, unhandled kinds
	task automatic test_event_kinds();
		send_word(mus_desc(1'b0, mme_pkg::KIND_NOTE_OFF, 4'd0), 1'b1);
		send_word(8'hff, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_NOTE_ON, 4'd9), 1'b0);
		send_word(8'h00, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_NOTE_ON, 4'd15), 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_PITCH, 4'd1), 1'b0);
		send_word(8'hff, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_SYSTEM, 4'd2), 1'b0);
		send_word(8'h0f, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_CTRL, 4'd3), 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_CTRL, 4'd3), 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(mus_desc(1'b1, mme_pkg::KIND_BAD5, 4'd4), 1'b0);
		send_word(8'h00, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_BAD7, 4'd4), 1'b0);
	endtask

	// delta saturation, score end, ignored bytes, restart mid-event
	task automatic test_delta_and_end();
		send_word(mus_desc(1'b1, mme_pkg::KIND_NOTE_OFF, 4'd0), 1'b1);
		send_word(8'h7f, 1'b0);
		repeat (5) send_word(8'hff, 1'b0);
		send_word(8'h7f, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_END, 4'd5), 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_NOTE_OFF, 4'd0), 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_NOTE_ON, 4'd15), 1'b1);
		send_word(8'h05, 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_CTRL, 4'd1), 1'b0);
		send_word(mus_desc(1'b0, mme_pkg::KIND_PITCH, 4'd0), 1'b1);
		send_word(8'h00, 1'b0);
	endtask

	// sender pauses until all results are out, between short scores
	task automatic test_drain_pause();
		repeat (3) begin
			send_rand_score($urandom_range(2, 6));
			wait_for_drain();
		end
	endtask

	// bulk random scores and noise, with some stretches of no idling
	task automatic test_random_scores();
		int target;
		int k;
		target = bytes_sent + RAND_BYTES;
		k = 0;
		while (bytes_sent < target) begin
			k++;
			idle_off = ((k % 25) >= 21);
			if ($urandom_range(0, 19) == 0) send_noise($urandom_range(4, 12));
			else send_rand_score($urandom_range(1, 12));
		end
		idle_off = 1'b0;
	endtask

	// output side stalls
	initial begin
		m_tready   = 1'b0;
		ready_hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (ready_hold != 0) begin
				ready_hold--;
			end else begin
				ready_hold = idle_off ? 0 : pick_gap();
				m_tready   = (ready_hold == 0);
				if (ready_hold != 0) ready_hold--;
			end
		end
	end

	// result word checker
	always @(posedge clk) begin : msg_check
		mme_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (midi_msg_q.size() == 0) begin
				report_mismatch("unexpected result word", m_tdata[31:0], 32'h0);
			end else begin
				want = midi_msg_q.pop_front();
				if (m_tdata[31:0] != want.delta_ticks)
					report_mismatch("delta_ticks", m_tdata[31:0], want.delta_ticks);
				if (m_tdata[39:32] != want.status)
					report_mismatch("status", 32'(m_tdata[39:32]), 32'(want.status));
				if (m_tdata[47:40] != want.data1)
					report_mismatch("data1", 32'(m_tdata[47:40]), 32'(want.data1));
				if (m_tdata[55:48] != want.data2)
					report_mismatch("data2", 32'(m_tdata[55:48]), 32'(want.data2));
				if (m_tuser[0] != want.score_end)
					report_mismatch("score_end", 32'(m_tuser[0]), 32'(want.score_end));
				if (m_tuser[1] != want.bad_event)
					report_mismatch("bad_event", 32'(m_tuser[1]), 32'(want.bad_event));
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("mus_to_midi_event_converter verification failed");
		$finish;
	end

	// main sequence
	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'h00;
		s_tuser    = 1'b0;
		idle_off   = 1'b0;
		err_cnt    = 0;
		bytes_sent = 0;
		cur_phase  = mme_pkg::PH_DESC;
		cur_chan   = '0;
		cur_kind   = '0;
		cur_last   = 1'b0;
		first_p    = '0;
		acc_delta  = '0;
		score_over = 1'b0;
		for (int i = 0; i < mme_pkg::NUM_CHANS; i++) chan_vol[i] = mme_pkg::VOL_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_event_kinds();
		test_delta_and_end();
		test_drain_pause();
		test_random_scores();
		wait_for_drain();

		if (err_cnt == 0) begin
			$display("mus_to_midi_event_converter verification clean");
		end else begin
			$display("mus_to_midi_event_converter verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/mme_pkg.sv
hw/rtl/mme_vol_table.sv
hw/rtl/mme_parser.sv
hw/rtl/mus_to_midi_event_converter.sv
tb/sv/tb_top.sv
